>>> hw/rtl/rc4d_pkg.sv
// Shared constants and types for the RC4-drop stream cipher.
`timescale 1ns / 1ps
package rc4d_pkg;

   localparam int KEY_DEPTH  = 256;
   localparam int DROP_COUNT = 1024;
   localparam int DROP_W     = (DROP_COUNT > 0) ? $clog2(DROP_COUNT + 1) : 1;

   typedef enum logic [1:0] {
      OP_KEY  = 2'd0,
      OP_INIT = 2'd1,
      OP_DATA = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_IDENT,
      ST_K0,
      ST_K1,
      ST_K2,
      ST_K3,
      ST_P0,
      ST_P1,
      ST_P2,
      ST_P3,
      ST_P4,
      ST_P5,
      ST_SAVE_RD,
      ST_SAVE_WR,
      ST_REST_RD,
      ST_REST_WR
   } state_type;

endpackage

>>> hw/rtl/rc4d_ram.sv
// 256 x 8 RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module rc4d_ram (
   input  logic       clock,
   input  logic       we,
   input  logic [7:0] waddr,
   input  logic [7:0] wdata,
   input  logic [7:0] raddr,
   output logic [7:0] rdata
);
   logic [7:0] mem [256];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> hw/rtl/rc4_drop_stream_cipher.sv
// Top level of the RC4-drop stream cipher with key store and saved start state.
//
// Input channel req_*: op, data_byte, restart. Op 0 stores a key byte (bytes past
// the key store depth are dropped), op 1 runs the key schedule, discards the first
// keystream bytes and saves the start state, op 2 encrypts/decrypts one byte.
// Result channel rsp_*: one word per op 2 item, data_byte XOR keystream byte.
// A key byte is stored as it is accepted. A data byte runs the keystream steps,
// after a restore of the saved S-box when restart is set. Init loads the identity
// permutation, runs the key schedule, drops DROP_COUNT keystream bytes and saves the state.
// The S-box RAM has one read port and one write port, and each keystream byte needs
// three reads and two writes in sequence.
// After reset a clearing pass loads the identity permutation into
// both S-box RAMs; req_ready stays low during it.
// The result sits in an output register; the next item is accepted while it
// waits, and a later data byte holds in its last step until rsp_ready frees it.
`timescale 1ns / 1ps
module rc4_drop_stream_cipher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_data_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte
);
   import rc4d_pkg::*;

   state_type         state_ff, state_in;
   logic [7:0]        n_ff, n_in;
   logic [7:0]        i_ff, i_in, j_ff, j_in;
   logic [7:0]        start_i_ff, start_i_in, start_j_ff, start_j_in;
   logic [7:0]        a_ff, a_in, b_ff, b_in;
   logic [7:0]        kidx_ff, kidx_in;
   logic [8:0]        key_count_ff, key_count_in;
   logic [DROP_W-1:0] drop_ff, drop_in;
   logic              dropping_ff, dropping_in;
   logic [7:0]        data_ff, data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;

   logic       p_we, s_we, k_we;
   logic [7:0] p_waddr, p_wdata, p_raddr, p_rdata;
   logic [7:0] s_waddr, s_wdata, s_raddr, s_rdata;
   logic [7:0] k_waddr, k_wdata, k_rdata;
   logic [7:0] sum_ab;

   rc4d_ram u_perm (.clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
                    .raddr(p_raddr), .rdata(p_rdata));
   rc4d_ram u_start (.clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
                     .raddr(s_raddr), .rdata(s_rdata));
   rc4d_ram u_key (.clock(clock), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
                   .raddr(kidx_ff), .rdata(k_rdata));

   assign sum_ab = a_ff + b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         start_i_ff   <= '0;
         start_j_ff   <= '0;
         key_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         start_i_ff   <= start_i_in;
         start_j_ff   <= start_j_in;
         key_count_ff <= key_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      kidx_ff     <= kidx_in;
      drop_ff     <= drop_in;
      dropping_ff <= dropping_in;
      data_ff     <= data_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      start_i_in   = start_i_ff;
      start_j_in   = start_j_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      kidx_in      = kidx_ff;
      key_count_in = key_count_ff;
      drop_in      = drop_ff;
      dropping_in  = dropping_ff;
      data_in      = data_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      p_we         = 1'b0;
      p_waddr      = n_ff;
      p_wdata      = n_ff;
      p_raddr      = n_ff;
      s_we         = 1'b0;
      s_waddr      = n_ff;
      s_wdata      = n_ff;
      s_raddr      = n_ff;
      k_we         = 1'b0;
      k_waddr      = key_count_ff[7:0];
      k_wdata      = req_data_byte;

      unique case (state_ff)
         ST_CLEAR: begin
            p_we = 1'b1;
            s_we = 1'b1;
            n_in = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (op_type'(req_op))
                  OP_KEY: begin
                     if (key_count_ff < 9'(KEY_DEPTH)) begin
                        k_we         = 1'b1;
                        key_count_in = key_count_ff + 9'd1;
                     end
                  end
                  OP_INIT: begin
                     n_in     = '0;
                     state_in = ST_IDENT;
                  end
                  OP_DATA: begin
                     data_in     = req_data_byte;
                     dropping_in = 1'b0;
                     n_in        = '0;
                     state_in    = req_restart ? ST_REST_RD : ST_P0;
                  end
                  default: ;
               endcase
            end
         end
         ST_IDENT: begin
            p_we = 1'b1;
            n_in = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               j_in    = '0;
               kidx_in = '0;
               i_in    = '0;
               drop_in = DROP_W'(DROP_COUNT);
               dropping_in = 1'b1;
               if (key_count_ff != 9'd0) begin
                  state_in = ST_K0;
               end else if (DROP_COUNT == 0) begin
                  state_in = ST_SAVE_RD;
               end else begin
                  state_in = ST_P0;
               end
            end
         end
         ST_K0: begin
            state_in = ST_K1;
         end
         ST_K1: begin
            a_in     = p_rdata;
            j_in     = j_ff + p_rdata + k_rdata;
            p_raddr  = j_in;
            state_in = ST_K2;
         end
         ST_K2: begin
            p_we     = 1'b1;
            p_wdata  = p_rdata;
            state_in = ST_K3;
         end
         ST_K3: begin
            p_we    = 1'b1;
            p_waddr = j_ff;
            p_wdata = a_ff;
            kidx_in = ({1'b0, kidx_ff} + 9'd1 == key_count_ff) ? 8'd0 : kidx_ff + 8'd1;
            n_in    = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               i_in = '0;
               j_in = '0;
               state_in = (DROP_COUNT == 0) ? ST_SAVE_RD : ST_P0;
            end else begin
               state_in = ST_K0;
            end
         end
         ST_P0: begin
            i_in     = i_ff + 8'd1;
            p_raddr  = i_in;
            state_in = ST_P1;
         end
         ST_P1: begin
            a_in     = p_rdata;
            j_in     = j_ff + p_rdata;
            p_raddr  = j_in;
            state_in = ST_P2;
         end
         ST_P2: begin
            b_in     = p_rdata;
            p_we     = 1'b1;
            p_waddr  = i_ff;
            p_wdata  = p_rdata;
            state_in = ST_P3;
         end
         ST_P3: begin
            p_we     = 1'b1;
            p_waddr  = j_ff;
            p_wdata  = a_ff;
            state_in = ST_P4;
         end
         ST_P4: begin
            p_raddr  = sum_ab;
            state_in = ST_P5;
         end
         ST_P5: begin
            p_raddr = sum_ab;
            if (dropping_ff) begin
               drop_in = drop_ff - DROP_W'(1);
               n_in    = '0;
               state_in = (drop_ff == DROP_W'(1)) ? ST_SAVE_RD : ST_P0;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = data_ff ^ p_rdata;
               state_in     = ST_IDLE;
            end
         end
         ST_SAVE_RD: begin
            state_in = ST_SAVE_WR;
         end
         ST_SAVE_WR: begin
            s_we    = 1'b1;
            s_wdata = p_rdata;
            n_in    = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               start_i_in   = i_ff;
               start_j_in   = j_ff;
               key_count_in = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SAVE_RD;
            end
         end
         ST_REST_RD: begin
            state_in = ST_REST_WR;
         end
         ST_REST_WR: begin
            p_we    = 1'b1;
            p_wdata = s_rdata;
            n_in    = n_ff + 8'd1;
            if (n_ff == 8'hff) begin
               i_in     = start_i_ff;
               j_in     = start_j_ff;
               state_in = ST_P0;
            end else begin
               state_in = ST_REST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
endmodule
